// ===== rtl/jfsp_pkg.sv =====
// jfsp_pkg: shared types, marker codes and status codes of the jpeg frame-size parser
// no dependencies; imported by jfsp_parser, jpeg_frame_size_parser_top and tb_top
package jfsp_pkg;

  localparam logic [7:0] MARK_PREFIX = 8'hFF;
  localparam logic [7:0] MARK_SOI    = 8'hD8;
  localparam logic [7:0] MARK_EOI    = 8'hD9;
  localparam logic [7:0] MARK_SOS    = 8'hDA;
  localparam logic [7:0] MARK_SOF_LO = 8'hC0;
  localparam logic [7:0] MARK_SOF_HI = 8'hCF;
  localparam logic [7:0] MARK_DHT    = 8'hC4;
  localparam logic [7:0] MARK_JPG    = 8'hC8;
  localparam logic [7:0] MARK_DAC    = 8'hCC;

  localparam logic [15:0] MIN_SEG_LEN = 16'd2;
  localparam logic [15:0] MIN_SOF_LEN = 16'd7;

  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_BADSTART = 3'd1;
  localparam logic [2:0] ST_EOI_SOS  = 3'd2;
  localparam logic [2:0] ST_SHORTLEN = 3'd3;
  localparam logic [2:0] ST_EARLYEND = 3'd4;
  localparam logic [2:0] ST_ZERODIM  = 3'd5;

  localparam int OUT_TDATA_W = 40;

  typedef struct packed {
    logic        valid;
    logic [2:0]  status;
    logic [15:0] width;
    logic [15:0] height;
  } jfsp_result_t;

  // start-of-frame markers: c0-cf except dht, jpg and dac
  function automatic logic is_frame_marker(input logic [7:0] m);
    logic in_range;
    in_range = (m >= MARK_SOF_LO) && (m <= MARK_SOF_HI);
    return in_range && (m != MARK_DHT) && (m != MARK_JPG) && (m != MARK_DAC);
  endfunction

endpackage

// ===== rtl/jfsp_parser.sv =====
// jfsp_parser: marker scanning state machine, one byte per enabled cycle
// depends on jfsp_pkg; result is combinational and registered by the top level
module jfsp_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic [7:0]            data_byte,
  input  logic                  final_byte,
  output jfsp_pkg::jfsp_result_t res
);
  import jfsp_pkg::*;

  typedef enum logic [3:0] {
    PH_START0 = 4'd0,
    PH_START1 = 4'd1,
    PH_SCAN   = 4'd2,
    PH_MARKER = 4'd3,
    PH_LEN_HI = 4'd4,
    PH_LEN_LO = 4'd5,
    PH_SKIP   = 4'd6,
    PH_PREC   = 4'd7,
    PH_H_HI   = 4'd8,
    PH_H_LO   = 4'd9,
    PH_W_HI   = 4'd10,
    PH_W_LO   = 4'd11
  } phase_t;

  phase_t      phase, phase_next;
  logic [15:0] skip_remaining, skip_remaining_next;
  logic [7:0]  length_high, length_high_next;
  logic [7:0]  current_marker, current_marker_next;
  logic [15:0] height_held, height_held_next;
  logic [7:0]  width_high, width_high_next;
  logic        decided, decided_next;

  logic [15:0] word;
  logic [15:0] skip_dec;

  assign word     = {length_high, data_byte};
  assign skip_dec = skip_remaining - 16'd1;

  always_comb begin
    logic [15:0] w;
    phase_next          = phase;
    skip_remaining_next = skip_remaining;
    length_high_next    = length_high;
    current_marker_next = current_marker;
    height_held_next    = height_held;
    width_high_next     = width_high;
    decided_next        = decided;
    res                 = '0;
    w                   = {width_high, data_byte};

    if (!decided) begin
      unique case (phase)
        PH_START0: begin
          if (data_byte != MARK_PREFIX || final_byte) begin
            res.valid  = 1'b1;
            res.status = ST_BADSTART;
          end else begin
            phase_next = PH_START1;
          end
        end
        PH_START1: begin
          if (data_byte != MARK_SOI) begin
            res.valid  = 1'b1;
            res.status = ST_BADSTART;
          end else begin
            phase_next = PH_SCAN;
          end
        end
        PH_SCAN: begin
          if (data_byte == MARK_PREFIX) phase_next = PH_MARKER;
        end
        PH_MARKER: begin
          if (data_byte == MARK_EOI || data_byte == MARK_SOS) begin
            res.valid  = 1'b1;
            res.status = ST_EOI_SOS;
          end else if (data_byte != MARK_PREFIX) begin
            // repeated ff is fill, stay here
            current_marker_next = data_byte;
            phase_next          = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          length_high_next = data_byte;
          phase_next       = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (word < MIN_SEG_LEN) begin
            res.valid  = 1'b1;
            res.status = ST_SHORTLEN;
          end else if (is_frame_marker(current_marker) && word >= MIN_SOF_LEN) begin
            phase_next = PH_PREC;
          end else begin
            skip_remaining_next = word - MIN_SEG_LEN;
            phase_next = (word == MIN_SEG_LEN) ? PH_SCAN : PH_SKIP;
          end
        end
        PH_SKIP: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == 16'd0) phase_next = PH_SCAN;
        end
        PH_PREC: phase_next = PH_H_HI;
        PH_H_HI: begin
          length_high_next = data_byte;
          phase_next       = PH_H_LO;
        end
        PH_H_LO: begin
          height_held_next = word;
          phase_next       = PH_W_HI;
        end
        PH_W_HI: begin
          width_high_next = data_byte;
          phase_next      = PH_W_LO;
        end
        PH_W_LO: begin
          res.valid = 1'b1;
          if (w == 16'd0 || height_held == 16'd0) begin
            res.status = ST_ZERODIM;
          end else begin
            res.status = ST_FOUND;
            res.width  = w;
            res.height = height_held;
          end
        end
        default: phase_next = PH_START0;
      endcase

      // a decision on the final byte wins over early end
      if (!res.valid && final_byte) begin
        res.valid  = 1'b1;
        res.status = ST_EARLYEND;
      end
      if (res.valid) decided_next = 1'b1;
    end

    // any final byte starts a new file
    if (final_byte) begin
      phase_next          = PH_START0;
      skip_remaining_next = '0;
      length_high_next    = '0;
      current_marker_next = '0;
      height_held_next    = '0;
      width_high_next     = '0;
      decided_next        = 1'b0;
    end

    if (!en) res.valid = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_START0;
      skip_remaining <= '0;
      length_high    <= '0;
      current_marker <= '0;
      height_held    <= '0;
      width_high     <= '0;
      decided        <= 1'b0;
    end else if (en) begin
      phase          <= phase_next;
      skip_remaining <= skip_remaining_next;
      length_high    <= length_high_next;
      current_marker <= current_marker_next;
      height_held    <= height_held_next;
      width_high     <= width_high_next;
      decided        <= decided_next;
    end
  end

endmodule

// ===== rtl/jpeg_frame_size_parser_top.sv =====
// jpeg_frame_size_parser_top: input register, parser state machine, result register
// depends on jfsp_pkg and jfsp_parser
//
//  channel  dir  tdata fields (lsb first)                    tlast
//  s_*      in   data_byte[7:0]                              final_byte
//  m_*      out  status[2:0] image_width[18:3]
//                image_height[34:19] zero pad[39:35]         -
//
// one byte per cycle while m_tready keeps up; a byte is parsed while it sits in the input
// register, and its result (if any) is captured in the result register that drives m_*.
// the parser advances only while the result register is empty or being drained,
// so a stalled m_tready holds at most one byte in the input register.
// rst is synchronous and returns the parser to expecting the ff d8 start.
module jpeg_frame_size_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte[7:0]
  input  logic        s_tlast,   // final_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [jfsp_pkg::OUT_TDATA_W-1:0] m_tdata  // status, image_width, image_height
);
  import jfsp_pkg::*;

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         in_final;
  logic         advance;
  jfsp_result_t res;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte  <= s_tdata;
      in_final <= s_tlast;
    end
  end

  jfsp_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .data_byte  (in_byte),
    .final_byte (in_final),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && res.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      m_tdata <= {5'd0, res.height, res.width, res.status};
    end
  end

endmodule

// ===== test/tb_top.sv =====
// tb_top: self-checking bench for jpeg_frame_size_parser_top, fed one file byte per transaction
// depends on jfsp_pkg and the rtl; a local parser model predicts each status/size result
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import jfsp_pkg::*;

  localparam logic [7:0] MARK_APP0 = 8'hE0;
  localparam logic [7:0] MARK_RST0 = 8'hD0;
  localparam logic [7:0] MARK_DQT  = 8'hDB;
  localparam logic [7:0] MARK_COM  = 8'hFE;

  localparam int RANDOM_BYTES = 1950;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 10;
  localparam int IDLE_PCT     = 26;

  typedef enum logic [3:0] {
    P_SOI0, P_SOI1, P_SCAN, P_MARK, P_LEN_HI, P_LEN_LO, P_SKIP,
    P_PREC, P_H_HI, P_H_LO, P_W_HI, P_W_LO
  } phase_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] width;
    logic [15:0] height;
  } frame_info_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;  // data_byte[7:0]
  logic s_tlast = 1'b0;      // final_byte
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;  // status[2:0] image_width[18:3] image_height[34:19]

  logic gaps_on = 1'b1;
  logic rx_hold = 1'b0;
  event hold_rx;

  frame_info_t expected_frames[$];
  logic [8:0]  file_q[$];  // {final_byte, data_byte}
  frame_info_t got, want;
  int errors = 0;
  int bytes_sent = 0;
  int live_bytes = 0;
  int files_sent = 0;
  int status_count[6];

  // parser model state
  phase_t      phase;
  logic [15:0] skip_left;
  logic [7:0]  len_hi;
  logic [7:0]  seg_marker;
  logic [15:0] height_q;
  logic [7:0]  width_hi;
  logic        file_done;

  jpeg_frame_size_parser_top u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #2 clk = ~clk;

  function automatic void reset_parser();
    phase = P_SOI0;
    skip_left = '0;
    len_hi = '0;
    seg_marker = '0;
    height_q = '0;
    width_hi = '0;
    file_done = 1'b0;
  endfunction

  // sof markers sit in c0-cf; c4, c8 and cc share low bits 00 with a nonzero middle pair
  function automatic logic is_sof(input logic [7:0] m);
    return (m[7:4] == 4'hC) && !((m[1:0] == 2'b00) && (m[3:2] != 2'b00));
  endfunction

  function automatic logic parse_byte(input logic [7:0] b, input logic fin,
                                      output frame_info_t res);
    logic        hit;
    logic [15:0] seg_len;
    logic [15:0] w;
    hit = 1'b0;
    res = '0;
    if (!file_done) begin
      case (phase)
        P_SOI0: begin
          if (b != MARK_PREFIX || fin) begin
            hit = 1'b1;
            res.status = ST_BADSTART;
          end else phase = P_SOI1;
        end
        P_SOI1: begin
          if (b != MARK_SOI) begin
            hit = 1'b1;
            res.status = ST_BADSTART;
          end else phase = P_SCAN;
        end
        P_SCAN: if (b == MARK_PREFIX) phase = P_MARK;
        P_MARK: begin
          if (b == MARK_EOI || b == MARK_SOS) begin
            hit = 1'b1;
            res.status = ST_EOI_SOS;
          end else if (b != MARK_PREFIX) begin
            seg_marker = b;
            phase = P_LEN_HI;
          end
        end
        P_LEN_HI: begin
          len_hi = b;
          phase = P_LEN_LO;
        end
        P_LEN_LO: begin
          seg_len = {len_hi, b};
          if (seg_len < MIN_SEG_LEN) begin
            hit = 1'b1;
            res.status = ST_SHORTLEN;
          end else if (is_sof(seg_marker) && seg_len >= MIN_SOF_LEN) begin
            phase = P_PREC;
          end else begin
            skip_left = seg_len - MIN_SEG_LEN;
            phase = (skip_left == 0) ? P_SCAN : P_SKIP;
          end
        end
        P_SKIP: begin
          skip_left = skip_left - 1'b1;
          if (skip_left == 0) phase = P_SCAN;
        end
        P_PREC: phase = P_H_HI;
        P_H_HI: begin
          len_hi = b;
          phase = P_H_LO;
        end
        P_H_LO: begin
          height_q = {len_hi, b};
          phase = P_W_HI;
        end
        P_W_HI: begin
          width_hi = b;
          phase = P_W_LO;
        end
        P_W_LO: begin
          w = {width_hi, b};
          hit = 1'b1;
          if (w == 0 || height_q == 0) res.status = ST_ZERODIM;
          else begin
            res.status = ST_FOUND;
            res.width = w;
            res.height = height_q;
          end
        end
        default: phase = P_SOI0;
      endcase
      if (!hit && fin) begin
        hit = 1'b1;
        res.status = ST_EARLYEND;
      end
      if (hit) file_done = 1'b1;
    end
    if (fin) reset_parser();
    return hit;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin);
    frame_info_t res;
    while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
    if (!file_done) live_bytes++;
    if (fin) files_sent++;
    if (parse_byte(b, fin, res)) expected_frames.push_back(res);
  endtask

  task automatic put(input logic [7:0] b);
    file_q.push_back({1'b0, b});
  endtask

  // flag the last queued byte as final and stream the whole file
  task automatic close_file();
    logic [8:0] item;
    item = file_q.pop_back();
    file_q.push_back({1'b1, item[7:0]});
    while (file_q.size() != 0) begin
      item = file_q.pop_front();
      send_byte(item[7:0], item[8]);
    end
  endtask

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_sof();
    logic [7:0] m;
    do m = MARK_SOF_LO | 8'($urandom_range(0, 15)); while (!is_sof(m));
    return m;
  endfunction

  function automatic logic [15:0] rand_dim();
    case ($urandom_range(0, 19))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h0001;
      default: return 16'($urandom_range(1, 65535));
    endcase
  endfunction

  // soi, a few ordinary segments with fill and stray bytes, then a frame header and trailing bytes
  task automatic build_good_file();
    int         len;
    logic [7:0] mk;
    logic [15:0] h, w;
    put(MARK_PREFIX);
    put(MARK_SOI);
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 2)) put(8'($urandom_range(0, 254)));
      put(MARK_PREFIX);
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) put(MARK_PREFIX);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: mk = MARK_APP0 | 8'($urandom_range(0, 15));
        4: mk = MARK_DQT;
        5: mk = MARK_DHT;
        6: mk = $urandom_range(0, 1) ? MARK_JPG : MARK_DAC;
        7: mk = MARK_RST0 | 8'($urandom_range(0, 7));
        8: mk = pick_sof();
        default: mk = MARK_COM;
      endcase
      if (is_sof(mk)) len = $urandom_range(2, 6);
      else if ($urandom_range(0, 19) == 0) len = $urandom_range(256, 300);
      else len = $urandom_range(2, 9);
      put(mk);
      put(8'(len >> 8));
      put(8'(len));
      repeat (len - 2) put(rand_byte());
    end
    put(MARK_PREFIX);
    put(pick_sof());
    put(8'h00);
    put(8'($urandom_range(7, 17)));
    put(rand_byte());
    h = rand_dim();
    w = rand_dim();
    put(h[15:8]);
    put(h[7:0]);
    put(w[15:8]);
    put(w[7:0]);
    repeat ($urandom_range(0, 5)) put(rand_byte());
  endtask

  always @(posedge clk)
    m_tready <= !rx_hold && (!gaps_on || $urandom_range(0, 99) >= IDLE_PCT);

  always begin
    @(hold_rx);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[2:0], m_tdata[18:3], m_tdata[34:19]};
      if (got.status < 6) status_count[got.status]++;
      if (expected_frames.size() == 0) begin
        $error("result with nothing expected: status %0d", got.status);
        errors++;
      end else begin
        want = expected_frames.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          errors++;
        end
        if (got.width !== want.width) begin
          $error("image_width: expected %0d, got %0d", want.width, got.width);
          errors++;
        end
        if (got.height !== want.height) begin
          $error("image_height: expected %0d, got %0d", want.height, got.height);
          errors++;
        end
      end
    end
  end

  // final on the first byte, and final on the d8 of the start marker
  task automatic test_start_marker();
    put(MARK_PREFIX);
    close_file();
    put(MARK_PREFIX); put(MARK_SOI);
    close_file();
  endtask

  // fill bytes before an eoi that lands on the final byte; rst marker with a
  // bare length of 2, then a length of 1 followed by an ignored byte
  task automatic test_marker_codes();
    put(MARK_PREFIX); put(MARK_SOI); put(MARK_PREFIX); put(MARK_PREFIX); put(MARK_EOI);
    close_file();
    put(MARK_PREFIX); put(MARK_SOI); put(MARK_PREFIX); put(MARK_RST0);
    put(8'h00); put(8'h02);
    put(MARK_PREFIX); put(MARK_DHT); put(8'h00); put(8'h01); put(8'h00);
    close_file();
  endtask

  // largest size decided on the final byte; zero width with trailing ignored byte
  task automatic test_frame_header();
    put(MARK_PREFIX); put(MARK_SOI); put(MARK_PREFIX); put(MARK_SOF_HI);
    put(8'h00); put(8'h07); put(8'h08);
    put(8'hFF); put(8'hFF); put(8'hFF); put(8'hFF);
    close_file();
    put(MARK_PREFIX); put(MARK_SOI); put(MARK_PREFIX); put(MARK_SOF_LO);
    put(8'h00); put(8'h07); put(8'h08);
    put(8'h00); put(8'h01); put(8'h00); put(8'h00); put(8'h00);
    close_file();
  endtask

  // one-byte files each yield a result while the output side is held off
  task automatic test_backpressure();
    -> hold_rx;
    repeat (40) begin
      put(rand_byte());
      close_file();
    end
  endtask

  task automatic test_random_files();
    int         pick, idx;
    logic [7:0] v;
    while (live_bytes < RANDOM_BYTES) begin
      // a stretch where neither side idles
      gaps_on <= !(live_bytes > RANDOM_BYTES / 3 && live_bytes < RANDOM_BYTES / 2);
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        build_good_file();
      end else if (pick < 80) begin
        build_good_file();
        idx = $urandom_range(0, file_q.size() - 1);
        while (file_q.size() > idx + 1) void'(file_q.pop_back());
      end else if (pick < 92) begin
        build_good_file();
        idx = $urandom_range(0, file_q.size() - 1);
        case ($urandom_range(0, 5))
          0: v = MARK_PREFIX;
          1: v = MARK_EOI;
          2: v = MARK_SOS;
          3: v = 8'h00;
          4: v = 8'h01;
          default: v = rand_byte();
        endcase
        file_q[idx] = {1'b0, v};
      end else begin
        if ($urandom_range(0, 1) == 1) begin
          put(MARK_PREFIX);
          put(MARK_SOI);
        end
        repeat ($urandom_range(1, 10))
          put($urandom_range(0, 3) == 0 ? MARK_PREFIX : rand_byte());
      end
      close_file();
    end
    gaps_on <= 1'b1;
  endtask

  initial begin
    reset_parser();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_start_marker();
    test_marker_codes();
    test_frame_header();
    test_backpressure();
    test_random_files();
    s_tvalid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run: %0d files in %0d bytes, output held off for %0d cycles once",
             files_sent, bytes_sent, HOLD_CYCLES);
    $display("results: found %0d, bad start %0d, eoi/sos %0d, short length %0d, early end %0d, zero size %0d",
             status_count[0], status_count[1], status_count[2], status_count[3],
             status_count[4], status_count[5]);
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/jfsp_pkg.sv
rtl/jfsp_parser.sv
rtl/jpeg_frame_size_parser_top.sv
test/tb_top.sv
